### sv/ps2s1_pkg.sv
// Package for the PS/2 set 1 key event decoder.
// Holds the payload types, key value codes and the extended-code remap table.
// No dependencies.
package ps2s1_pkg;

    localparam int KEY_COUNT  = 128;
    localparam int KEY_ADDR_W = $clog2(KEY_COUNT);

    typedef logic [7:0]            scan_byte_t;
    typedef logic [KEY_ADDR_W-1:0] key_code_t;
    typedef logic [1:0]            key_value_t;

    localparam scan_byte_t PREFIX_EXT  = 8'hE0;
    localparam int         RELEASE_BIT = 7;

    localparam key_value_t KEY_RELEASE = 2'd0;
    localparam key_value_t KEY_PRESS   = 2'd1;
    localparam key_value_t KEY_REPEAT  = 2'd2;

    function automatic key_code_t remap_extended(input key_code_t code);
        key_code_t result;
        case (code)
            7'h1C:   result = 7'd96;
            7'h1D:   result = 7'd97;
            7'h35:   result = 7'd98;
            7'h38:   result = 7'd100;
            7'h47:   result = 7'd102;
            7'h48:   result = 7'd103;
            7'h49:   result = 7'd104;
            7'h4B:   result = 7'd105;
            7'h4D:   result = 7'd106;
            7'h4F:   result = 7'd107;
            7'h50:   result = 7'd108;
            7'h51:   result = 7'd109;
            7'h52:   result = 7'd110;
            7'h53:   result = 7'd111;
            default: result = code;
        endcase
        return result;
    endfunction

endpackage

### sv/ps2s1_scan_if.sv
// Valid/ready channel that carries one raw scancode byte per word.
// Depends on ps2s1_pkg.
interface ps2s1_scan_if
    import ps2s1_pkg::*;
();
    logic       valid;
    logic       ready;
    scan_byte_t scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink (input valid, input scan_byte, output ready);
endinterface

### sv/ps2s1_key_if.sv
// Valid/ready channel that carries one key event (code and value) per word.
// Depends on ps2s1_pkg.
interface ps2s1_key_if
    import ps2s1_pkg::*;
();
    logic       valid;
    logic       ready;
    key_code_t  key_code;
    key_value_t key_value;

    modport source (output valid, output key_code, output key_value, input ready);
    modport sink (input valid, input key_code, input key_value, output ready);
endinterface

### sv/ps2s1_set1_scancode_to_key_event_core.sv
// Top level of the PS/2 scancode set 1 to key event decoder.
// Depends on ps2s1_pkg, ps2s1_scan_if and ps2s1_key_if.
//
// The decoder accepts one scancode byte per clock cycle unless the key channel stalls
// and delivers the key event in an output register. The key-down bitmap lives in a
// 128 x 1 synchronous memory: the byte reads its bit in the cycle it is accepted,
// and the next stage computes press, release or repeat and writes the bit back,
// with the written bit forwarded to a read of the same key in that cycle. A valid
// flop per entry is cleared by reset, so the decoder is ready right after reset
// with no clearing pass. An extended prefix byte produces no word.
module ps2_set1_scancode_to_key_event_core
    import ps2s1_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ps2s1_scan_if.sink    scan,
    ps2s1_key_if.source   key
);

    logic                 key_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] key_vld_reg;

    logic       ext_reg;
    logic       s1_valid_reg;
    key_code_t  s1_code_reg;
    logic       s1_release_reg;
    logic       mem_rd_reg;
    logic       vld_rd_reg;
    logic       fwd_reg;
    logic       fwd_bit_reg;

    logic       out_valid_reg;
    key_code_t  out_code_reg;
    key_value_t out_value_reg;

    logic       out_free;
    logic       s1_adv;
    logic       in_acc;
    logic       is_prefix;
    logic       in_release;
    key_code_t  in_code;
    logic       s1_down;
    logic       s1_repeat;
    logic       s1_wr;
    key_value_t s1_value;

    assign out_free   = !out_valid_reg || key.ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign scan.ready = !s1_valid_reg || out_free;
    assign in_acc     = scan.valid && scan.ready;

    assign is_prefix  = (scan.scan_byte == PREFIX_EXT);
    assign in_release = scan.scan_byte[RELEASE_BIT];
    assign in_code    = ext_reg ? remap_extended(scan.scan_byte[KEY_ADDR_W-1:0])
                                : scan.scan_byte[KEY_ADDR_W-1:0];

    assign s1_down   = fwd_reg ? fwd_bit_reg : (vld_rd_reg && mem_rd_reg);
    assign s1_repeat = !s1_release_reg && s1_down;
    assign s1_wr     = s1_adv && !s1_repeat;

    always_comb
    begin
        if (s1_repeat)
        begin
            s1_value = KEY_REPEAT;
        end
        else if (s1_release_reg)
        begin
            s1_value = KEY_RELEASE;
        end
        else
        begin
            s1_value = KEY_PRESS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_wr)
        begin
            key_mem[s1_code_reg] <= !s1_release_reg;
        end
        if (in_acc && !is_prefix)
        begin
            mem_rd_reg     <= key_mem[in_code];
            vld_rd_reg     <= key_vld_reg[in_code];
            fwd_reg        <= s1_wr && (s1_code_reg == in_code);
            fwd_bit_reg    <= !s1_release_reg;
            s1_code_reg    <= in_code;
            s1_release_reg <= in_release;
        end
        if (s1_adv)
        begin
            out_code_reg  <= s1_code_reg;
            out_value_reg <= s1_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg   <= '0;
            ext_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_wr)
            begin
                key_vld_reg[s1_code_reg] <= 1'b1;
            end
            if (in_acc)
            begin
                ext_reg <= is_prefix;
            end
            if (in_acc && !is_prefix)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (key.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign key.valid     = out_valid_reg;
    assign key.key_code  = out_code_reg;
    assign key.key_value = out_value_reg;

    a_prefix_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_prefix) |=> ext_reg)
        else $error("extended flag not armed after prefix byte");

    a_code_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !is_prefix) |=> (s1_valid_reg && !ext_reg))
        else $error("scancode byte not loaded or extended flag not cleared");

    a_value_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_value_reg == KEY_RELEASE || out_value_reg == KEY_PRESS
                           || out_value_reg == KEY_REPEAT))
        else $error("illegal key value in output register");

    a_repeat_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_value == KEY_REPEAT) |-> !s1_wr)
        else $error("bitmap written on repeat");

endmodule

### sim/ps2s1_key_event_checker.sv
// Checker for the PS/2 set 1 key event decoder: watches the scancode and key channels,
// predicts each key event from the accepted bytes and compares it with the delivered word.
// Depends on ps2s1_pkg, ps2s1_scan_if and ps2s1_key_if.
module ps2s1_key_event_checker
    import ps2s1_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ps2s1_scan_if scan,
    ps2s1_key_if  key,
    output int    fail_count,
    output int    pending_count,
    output int    press_count,
    output int    release_count,
    output int    repeat_count
);

    typedef struct packed {
        key_code_t  code;
        key_value_t value;
    } key_event_t;

    logic                 ext_armed;
    logic [KEY_COUNT-1:0] down_map;
    key_event_t           expected_events[$];
    key_event_t           predicted;
    key_event_t           got;
    key_event_t           want;

    function automatic key_code_t translate_extended_code(input key_code_t code);
        key_code_t result;
        case (code)
            7'h1C:   result = 7'd96;
            7'h1D:   result = 7'd97;
            7'h35:   result = 7'd98;
            7'h38:   result = 7'd100;
            7'h47:   result = 7'd102;
            7'h48:   result = 7'd103;
            7'h49:   result = 7'd104;
            7'h4B:   result = 7'd105;
            7'h4D:   result = 7'd106;
            7'h4F:   result = 7'd107;
            7'h50:   result = 7'd108;
            7'h51:   result = 7'd109;
            7'h52:   result = 7'd110;
            7'h53:   result = 7'd111;
            default: result = code;
        endcase
        return result;
    endfunction

    // Updates the prefix flag and the key-down bitmap; returns 1 when the byte makes an event.
    function automatic bit decode_scan_byte(input scan_byte_t b, output key_event_t ev);
        key_code_t code;
        logic      released;
        ev = '0;
        if (b == PREFIX_EXT) begin
            ext_armed = 1'b1;
            return 1'b0;
        end
        released = b[RELEASE_BIT];
        code = b[6:0];
        if (ext_armed) begin
            code = translate_extended_code(code);
            ext_armed = 1'b0;
        end
        ev.code = code;
        if (!released && down_map[code]) begin
            ev.value = KEY_REPEAT;
        end
        else begin
            down_map[code] = !released;
            ev.value = released ? KEY_RELEASE : KEY_PRESS;
        end
        return 1'b1;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ext_armed = 1'b0;
            down_map = '0;
            expected_events.delete();
            fail_count = 0;
            pending_count = 0;
            press_count = 0;
            release_count = 0;
            repeat_count = 0;
        end
        else begin
            if (scan.valid && scan.ready) begin
                if (decode_scan_byte(scan.scan_byte, predicted)) begin
                    expected_events.push_back(predicted);
                end
            end
            if (key.valid && key.ready) begin
                got.code = key.key_code;
                got.value = key.key_value;
                if (expected_events.size() == 0) begin
                    note_failure($sformatf("unexpected key word code %0d value %0d",
                                           got.code, got.value));
                end
                else begin
                    want = expected_events.pop_front();
                    if (got.code !== want.code) begin
                        note_failure($sformatf("key_code expected %0d got %0d",
                                               want.code, got.code));
                    end
                    if (got.value !== want.value) begin
                        note_failure($sformatf("key_value for code %0d expected %0d got %0d",
                                               want.code, want.value, got.value));
                    end
                    case (want.value)
                        KEY_PRESS:   press_count++;
                        KEY_RELEASE: release_count++;
                        default:     repeat_count++;
                    endcase
                end
            end
            pending_count = expected_events.size();
        end
    end

endmodule

### sim/tb_ps2_set1_scancode_to_key_event_core.sv
// Testbench top for the PS/2 set 1 key event decoder: drives scancode bytes with random
// gaps, stalls the key channel at random and reports the verdict from the checker.
// Depends on ps2s1_pkg, both channel interfaces, the decoder and ps2s1_key_event_checker.
module tb_ps2_set1_scancode_to_key_event_core
    import ps2s1_pkg::*;
();

    localparam int RANDOM_BYTES = 1050;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   press_count;
    int   release_count;
    int   repeat_count;
    int   bytes_sent;
    int   prefixes_sent;
    int   source_mode;
    int   sink_mode;

    logic [6:0] ext_codes [0:13] = '{7'h1C, 7'h1D, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49,
                                     7'h4B, 7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53};

    ps2s1_scan_if scan_ch();
    ps2s1_key_if  key_ch();

    ps2_set1_scancode_to_key_event_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_ch),
        .key   (key_ch)
    );

    ps2s1_key_event_checker key_event_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .scan          (scan_ch),
        .key           (key_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .press_count   (press_count),
        .release_count (release_count),
        .repeat_count  (repeat_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // Mode 0 never waits, mode 1 draws a random wait on every call, mode 2 waits only now and then.
    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 13);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic logic [6:0] pick_code(input bit ext);
        if (ext && $urandom_range(0, 3) != 0)
        begin
            return ext_codes[4'($urandom_range(0, 13))];
        end
        case ($urandom_range(0, 3))
            0:       return ext_codes[4'($urandom_range(0, 13))];
            1:       return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(8'h10, 8'h1F));
        endcase
    endfunction

    task automatic send_byte(input scan_byte_t b);
        int gap;
        gap = draw_wait(source_mode);
        if (gap > 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_ch.valid <= 1'b1;
        scan_ch.scan_byte <= b;
        @(posedge clk);
        while (!scan_ch.ready) @(posedge clk);
        bytes_sent++;
        if (b == PREFIX_EXT)
        begin
            prefixes_sent++;
        end
    endtask

    task automatic send_key(input bit ext, input logic [6:0] code, input bit released);
        if (ext)
        begin
            send_byte(PREFIX_EXT);
        end
        send_byte({released, code});
    endtask

    // A well-formed stroke: one or more makes, usually followed by the break.
    task automatic send_keystroke();
        bit         ext;
        logic [6:0] code;
        ext = 1'($urandom_range(0, 1));
        code = pick_code(ext);
        repeat ($urandom_range(1, 4)) send_key(ext, code, 1'b0);
        if ($urandom_range(0, 7) != 0)
        begin
            send_key(ext, code, 1'b1);
        end
    endtask

    initial
    begin
        key_ch.ready <= 1'b0;
        sink_mode = 1;
        wait (rst_n === 1'b1);
        forever
        begin
            int stall;
            if ($urandom_range(0, 63) == 0)
            begin
                sink_mode = $urandom_range(0, 2);
            end
            stall = draw_wait(sink_mode);
            if (stall > 0)
            begin
                key_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            key_ch.ready <= 1'b1;
            @(posedge clk);
            while (!key_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        int start_count;
        int next_switch;
        int pick;
        rst_n = 1'b0;
        scan_ch.valid <= 1'b0;
        scan_ch.scan_byte <= '0;
        bytes_sent = 0;
        prefixes_sent = 0;
        source_mode = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of the byte, press, repeat and release, remapped keys,
        // a doubled prefix, an unmapped extended code and a release of a key not down.
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_key(1'b1, 7'h1C, 1'b0);
        send_key(1'b1, 7'h1C, 1'b1);
        send_byte(PREFIX_EXT);
        send_key(1'b1, 7'h48, 1'b0);
        send_key(1'b1, 7'h48, 1'b1);
        send_key(1'b1, 7'h10, 1'b0);
        send_byte(8'h10);
        send_byte(8'h90);
        send_key(1'b1, 7'h53, 1'b0);
        send_key(1'b1, 7'h53, 1'b1);
        send_byte(8'hAA);

        start_count = bytes_sent;
        next_switch = bytes_sent + 100;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            if (bytes_sent >= next_switch)
            begin
                source_mode = $urandom_range(0, 2);
                next_switch = bytes_sent + $urandom_range(50, 150);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                send_keystroke();
            end
            else if (pick < 72)
            begin
                send_byte(PREFIX_EXT);
                send_key(1'b1, pick_code(1'b1), 1'($urandom_range(0, 1)));
            end
            else if (pick < 84)
            begin
                send_key(1'($urandom_range(0, 1)), pick_code(1'b0), 1'b1);
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        scan_ch.valid <= 1'b0;

        do @(posedge clk); while (pending_count != 0);
        repeat (10) @(posedge clk);

        $display("Sent %0d scancode bytes, %0d of them extended prefixes.",
                 bytes_sent, prefixes_sent);
        $display("Checked %0d presses, %0d releases and %0d repeats; %0d mismatches.",
                 press_count, release_count, repeat_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
